### src/l2bpg_pkg.sv
// Shared constants and codes for the L2 ball projected gradient kernel.
`default_nettype none
package l2bpg_pkg;

	localparam int WORD_BITS_DEF = 48;
	localparam int FRAC_BITS_DEF = 32;

	// absolute tolerance term: round(2^(2F) / 1e8)
	localparam int unsigned TOL_ABS_DIV  = 100000000;
	localparam int unsigned TOL_ABS_HALF = 50000000;
	// relative tolerance term: round(r^2 / 1e5)
	localparam int unsigned TOL_REL_DIV  = 100000;
	localparam int unsigned TOL_REL_HALF = 50000;
	localparam int REL_REM_BITS = 17;
	localparam int REL_DIGITS   = 8;

	typedef enum logic [1:0] {
		MODE_PROJECT = 2'd0,
		MODE_MASK    = 2'd1,
		MODE_REDUCED = 2'd2
	} mode_t;

endpackage
`default_nettype wire

### src/l2_ball_projected_gradient.sv
// Streaming ball projection / reduced projected gradient kernel, one triplet per cycle while not stalled.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------------
//  in      | in_valid / in_stall    | mode, x_*, grad_*, radius
//  out     | out_valid / out_stall  | res_first, res_second, res_third, on_surface, scaled
//  cfg     | cfg_valid / cfg_ready  | cfg_data (step size alpha)
//
// One beat enters per cycle while in_stall is low; the pipeline depth is set by the
// square root and the two restoring divider chains, one bit per stage.
// The last stage is the output register; while it holds a stalled beat the whole
// pipe freezes and in_stall rises in the same cycle.
// Reset clears the valid bits and loads alpha with 1.0; no clearing pass is needed.
`default_nettype none
module l2_ball_projected_gradient #(
	parameter int WORD_BITS = l2bpg_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = l2bpg_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  mode,
	input  wire logic signed [WORD_BITS-1:0] x_first,
	input  wire logic signed [WORD_BITS-1:0] x_second,
	input  wire logic signed [WORD_BITS-1:0] x_third,
	input  wire logic signed [WORD_BITS-1:0] grad_first,
	input  wire logic signed [WORD_BITS-1:0] grad_second,
	input  wire logic signed [WORD_BITS-1:0] grad_third,
	input  wire logic [WORD_BITS-2:0]        radius,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [WORD_BITS-1:0]      res_first,
	output logic signed [WORD_BITS-1:0]      res_second,
	output logic signed [WORD_BITS-1:0]      res_third,
	output logic                             on_surface,
	output logic                             scaled,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [WORD_BITS-2:0]        cfg_data
);
	import l2bpg_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int H   = (W + 1) / 2;
	localparam int PW  = 2 * H;
	localparam int ZW  = 4 * H;
	localparam int MW  = 2 * W + 1 - F;
	localparam int XW  = 2 * W + 2;
	localparam int DW  = 2 * W + 2;
	localparam int TW  = ((2 * F > 2 * W) ? 2 * F : 2 * W) + 2;
	localparam int CWD = (F > W - 1) ? F : W - 1;
	localparam int ND  = (2 * W + REL_DIGITS - 1) / REL_DIGITS;

	localparam int ST_ABS = 1;
	localparam int ST_PP  = 2;
	localparam int ST_PR  = 3;
	localparam int ST_SUM = 4;
	localparam int ST_V   = 5;
	localparam int ST_U   = 6;
	localparam int ST_UPP = 7;
	localparam int ST_UPR = 8;
	localparam int ST_N2  = 9;
	localparam int SQ0    = 10;
	localparam int DV0    = SQ0 + W;
	localparam int DF     = DV0 + W - 1;
	localparam int DA0    = DF + 1;
	localparam int NST    = DA0 + W;
	localparam int CD0    = ST_V;
	localparam int TOLS   = CD0 + ND;
	localparam int CMPS   = TOLS + 1;

	localparam logic [TW-1:0] TOL0 = TW'(((192'd1 << (2 * F)) + 192'(TOL_ABS_HALF))
		/ 192'(TOL_ABS_DIV));
	localparam logic [W-2:0]  STEP_RST = (W - 1)'(192'd1 << F);
	localparam logic [2*W:0]  RND      = (2 * W + 1)'(192'd1 << (F - 1));
	localparam logic [W-1:0]  MAX_W    = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0]  MIN_W    = {1'b1, {(W - 1){1'b0}}};
	localparam logic signed [XW-1:0] SAT_HI = XW'(MAX_W);
	localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

	typedef struct packed {
		logic [1:0]                  mode;
		logic [2:0][W-1:0]           x;
		logic [2:0][W-1:0]           g;
		logic [W-2:0]                r;
		logic [W-2:0]                alpha;
		logic [2:0][W-1:0]           xa;
		logic [2:0]                  xn;
		logic [2:0][W-1:0]           ga;
		logic [2:0]                  gn;
		logic [9:0][3:0][PW-1:0]     pp;
		logic [9:0][2*W-1:0]         pr;
		logic [2*W-1:0]              xm2;
		logic [DW-1:0]               dot;
		logic                        dot_pos;
		logic [2:0][MW-1:0]          m;
		logic [2:0][W-1:0]           v;
		logic [2*W-1:0]              sq_gap;
		logic [2*W-1:0]              cd_num;
		logic [REL_REM_BITS-1:0]     cd_rem;
		logic [2*W-1:0]              cd_q;
		logic [TW-1:0]               tol;
		logic                        gt;
		logic                        eq;
		logic [2:0][W-1:0]           u;
		logic [2:0][W-1:0]           ua;
		logic [2:0]                  un;
		logic [5:0][3:0][PW-1:0]     pq;
		logic [5:0][2*W-1:0]         uq;
		logic [2*W-1:0]              n2;
		logic                        proj;
		logic [W-1:0]                root;
		logic [W+1:0]                srem;
		logic [2:0][W:0]             drem;
		logic [2:0][W-2:0]           q;
		logic [2:0][W-1:0]           p;
		logic [2:0][W-1:0]           da;
		logic [2:0]                  dn;
		logic [2:0][W+F-1:0]         num;
		logic [2:0]                  ovf;
		logic [2:0][W-1:0]           arem;
		logic [2:0][W-1:0]           q2;
		logic [2:0][W-1:0]           res;
		logic                        on;
		logic                        scaled;
	} item_t;

	logic [W-2:0] step_q;
	logic         en;
	item_t        item_s [0:NST];
	logic         vld_s  [0:NST];

	// split a W x W product into four half-width partial products
	function automatic logic [3:0][PW-1:0] mul_parts(input logic [W-1:0] a,
		input logic [W-1:0] b);
		logic [H-1:0] al, ah, bl, bh;
		logic [3:0][PW-1:0] pt;
		al = a[H-1:0];
		ah = H'(a >> H);
		bl = b[H-1:0];
		bh = H'(b >> H);
		pt[0] = PW'(al) * PW'(bl);
		pt[1] = PW'(al) * PW'(bh);
		pt[2] = PW'(ah) * PW'(bl);
		pt[3] = PW'(ah) * PW'(bh);
		return pt;
	endfunction

	function automatic logic [2*W-1:0] mul_join(input logic [3:0][PW-1:0] pt);
		logic [ZW-1:0] s;
		s = (ZW'(pt[3]) << (2 * H)) + ((ZW'(pt[1]) + ZW'(pt[2])) << H) + ZW'(pt[0]);
		return s[2*W-1:0];
	endfunction

	function automatic logic [W-1:0] sat_w(input logic signed [XW-1:0] v);
		logic [W-1:0] o;
		if (v > SAT_HI)
			o = MAX_W;
		else if (v < SAT_LO)
			o = MIN_W;
		else
			o = v[W-1:0];
		return o;
	endfunction

	function automatic logic [W-1:0] div_sat(input logic ovf, input logic neg,
		input logic [W-1:0] qv);
		logic [W-1:0] o;
		if (ovf)
			o = neg ? MIN_W : MAX_W;
		else if (!neg)
			o = (qv > MAX_W) ? MAX_W : qv;
		else
			o = (qv > MIN_W) ? MIN_W : -qv;
		return o;
	endfunction

	function automatic item_t stage_fn(input int k, input item_t a);
		item_t b;
		int j;
		int bi;
		logic [2*W:0] rt;
		logic signed [XW-1:0] xs, mm;
		logic [DW-1:0] term;
		logic [REL_REM_BITS:0] rr;
		logic [W+1:0] st, trial;
		logic [W:0] t1, qe;
		logic signed [W:0] pe, d, nd;
		logic [F-1:0] hi;
		logic [W-1:0] t2;
		b = a;

		if (k == ST_ABS) begin
			for (int c = 0; c < 3; c++) begin
				b.xn[c] = a.x[c][W-1];
				b.xa[c] = b.xn[c] ? -a.x[c] : a.x[c];
				b.gn[c] = a.g[c][W-1];
				b.ga[c] = b.gn[c] ? -a.g[c] : a.g[c];
			end
		end

		if (k == ST_PP) begin
			for (int c = 0; c < 3; c++) begin
				b.pp[c]     = mul_parts(a.xa[c], a.xa[c]);
				b.pp[3 + c] = mul_parts(a.xa[c], a.ga[c]);
				b.pp[6 + c] = mul_parts(W'(a.alpha), a.ga[c]);
			end
			b.pp[9] = mul_parts(W'(a.r), W'(a.r));
		end

		if (k == ST_PR) begin
			for (int c = 0; c < 10; c++)
				b.pr[c] = mul_join(a.pp[c]);
		end

		if (k == ST_SUM) begin
			b.xm2 = a.pr[0] + a.pr[1] + a.pr[2];
			b.dot = '0;
			for (int c = 0; c < 3; c++) begin
				term  = DW'(a.pr[3 + c]);
				b.dot = b.dot + ((a.xn[c] ^ a.gn[c]) ? -term : term);
				// round alpha*|g| to F fraction bits, half away from zero
				rt       = {1'b0, a.pr[6 + c]} + RND;
				b.m[c]   = MW'(rt >> F);
			end
			b.cd_num = a.pr[9] + (2 * W)'(TOL_REL_HALF);
			b.cd_rem = '0;
			b.cd_q   = '0;
		end

		if (k == ST_V) begin
			for (int c = 0; c < 3; c++) begin
				xs       = XW'($signed(a.x[c]));
				mm       = XW'(a.m[c]);
				b.v[c]   = sat_w(a.gn[c] ? xs + mm : xs - mm);
			end
			b.sq_gap  = (a.xm2 >= a.pr[9]) ? a.xm2 - a.pr[9] : a.pr[9] - a.xm2;
			b.dot_pos = !a.dot[DW-1] && (a.dot != '0);
		end

		// r^2 / 1e5, several quotient bits per stage
		if (k >= CD0 && k < CD0 + ND) begin
			j = k - CD0;
			for (int t = 0; t < REL_DIGITS; t++) begin
				bi = ND * REL_DIGITS - 1 - (j * REL_DIGITS + t);
				if (bi < 2 * W)
					rr = {b.cd_rem, b.cd_num[bi]};
				else
					rr = {b.cd_rem, 1'b0};
				if (rr >= (REL_REM_BITS + 1)'(TOL_REL_DIV)) begin
					rr = rr - (REL_REM_BITS + 1)'(TOL_REL_DIV);
					if (bi < 2 * W)
						b.cd_q[bi] = 1'b1;
				end
				b.cd_rem = rr[REL_REM_BITS-1:0];
			end
		end

		if (k == TOLS)
			b.tol = TOL0 + TW'(a.cd_q);

		if (k == CMPS) begin
			b.gt = TW'(a.sq_gap) > a.tol;
			b.eq = TW'(a.sq_gap) == a.tol;
		end

		if (k == ST_U) begin
			for (int c = 0; c < 3; c++) begin
				b.u[c]  = (mode_t'(a.mode) == MODE_PROJECT) ? a.x[c] : a.v[c];
				b.un[c] = b.u[c][W-1];
				b.ua[c] = b.un[c] ? -b.u[c] : b.u[c];
			end
		end

		if (k == ST_UPP) begin
			for (int c = 0; c < 3; c++) begin
				b.pq[c]     = mul_parts(a.ua[c], a.ua[c]);
				b.pq[3 + c] = mul_parts(a.ua[c], W'(a.r));
			end
		end

		if (k == ST_UPR) begin
			for (int c = 0; c < 6; c++)
				b.uq[c] = mul_join(a.pq[c]);
		end

		if (k == ST_N2) begin
			b.n2   = a.uq[0] + a.uq[1] + a.uq[2];
			b.proj = b.n2 > a.pr[9];
			b.root = '0;
			b.srem = '0;
		end

		// floor square root, one root bit per stage
		if (k >= SQ0 && k < SQ0 + W) begin
			bi    = W - 1 - (k - SQ0);
			st    = {a.srem[W-1:0], a.n2[2 * bi + 1], a.n2[2 * bi]};
			trial = {a.root, 2'b01};
			if (st >= trial) begin
				b.srem = st - trial;
				b.root = {a.root[W-2:0], 1'b1};
			end else begin
				b.srem = st;
				b.root = {a.root[W-2:0], 1'b0};
			end
		end

		// |u| * r / root, one quotient bit per stage
		if (k >= DV0 && k < DV0 + W - 1) begin
			j  = k - DV0;
			bi = W - 2 - j;
			for (int c = 0; c < 3; c++) begin
				t1 = (j == 0) ? (W + 1)'(a.uq[3 + c] >> (W - 1)) : a.drem[c];
				t1 = {t1[W-1:0], a.uq[3 + c][bi]};
				if (t1 >= (W + 1)'(a.root)) begin
					b.drem[c]  = t1 - (W + 1)'(a.root);
					b.q[c][bi] = 1'b1;
				end else begin
					b.drem[c]  = t1;
					b.q[c][bi] = 1'b0;
				end
			end
		end

		if (k == DF) begin
			for (int c = 0; c < 3; c++) begin
				qe = (W + 1)'(a.q[c]);
				if (a.proj)
					pe = a.un[c] ? -$signed(qe) : $signed(qe);
				else
					pe = (W + 1)'($signed(a.u[c]));
				b.p[c]   = pe[W-1:0];
				d        = (W + 1)'($signed(a.x[c])) - pe;
				nd       = -d;
				b.dn[c]  = d[W];
				b.da[c]  = d[W] ? nd[W-1:0] : d[W-1:0];
				b.num[c] = {b.da[c], {F{1'b0}}};
				hi       = b.num[c][W+F-1:W];
				// quotient would reach 2^W: saturate without dividing
				b.ovf[c]  = CWD'(hi) >= CWD'(a.alpha);
				b.arem[c] = W'(CWD'(hi));
			end
		end

		// (x - p) << F / alpha, one quotient bit per stage
		if (k >= DA0 && k < DA0 + W) begin
			bi = W - 1 - (k - DA0);
			for (int c = 0; c < 3; c++) begin
				t2 = {a.arem[c][W-2:0], a.num[c][bi]};
				if (t2 >= W'(a.alpha)) begin
					b.arem[c]   = t2 - W'(a.alpha);
					b.q2[c][bi] = 1'b1;
				end else begin
					b.arem[c]   = t2;
					b.q2[c][bi] = 1'b0;
				end
			end
		end

		if (k == NST) begin
			b.on     = !a.gt;
			b.scaled = 1'b0;
			b.res    = '0;
			unique case (mode_t'(a.mode))
				MODE_PROJECT: begin
					b.res    = a.p;
					b.scaled = a.proj;
				end
				MODE_MASK: begin
					if (a.gt)
						b.res = a.g;
				end
				MODE_REDUCED: begin
					if (a.gt || (!a.eq && a.dot_pos)) begin
						b.res = a.g;
					end else if (!a.eq) begin
						for (int c = 0; c < 3; c++)
							b.res[c] = div_sat(a.ovf[c], a.dn[c], a.q2[c]);
						b.scaled = a.proj;
					end
				end
				default: begin
					b.res = '0;
				end
			endcase
		end

		return b;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_RST;
		else if (cfg_valid)
			step_q <= cfg_data;
	end

	always_comb begin
		item_s[0]       = '0;
		item_s[0].mode  = mode;
		item_s[0].x[0]  = x_first;
		item_s[0].x[1]  = x_second;
		item_s[0].x[2]  = x_third;
		item_s[0].g[0]  = grad_first;
		item_s[0].g[1]  = grad_second;
		item_s[0].g[2]  = grad_third;
		item_s[0].r     = radius;
		// a zero step acts as one LSB
		item_s[0].alpha = (step_q == '0) ? (W - 1)'(1) : step_q;
	end

	assign vld_s[0] = in_valid;
	assign en       = !(vld_s[NST] && out_stall);
	assign in_stall = !en;

	for (genvar k = 1; k <= NST; k++) begin : g_pipe
		always_ff @(posedge clk) begin
			if (en)
				item_s[k] <= stage_fn(k, item_s[k-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_s[k-1];
		end
	end

	assign out_valid  = vld_s[NST];
	assign res_first  = item_s[NST].res[0];
	assign res_second = item_s[NST].res[1];
	assign res_third  = item_s[NST].res[2];
	assign on_surface = item_s[NST].on;
	assign scaled     = item_s[NST].scaled;

endmodule
`default_nettype wire

### src/l2bpg_checker.sv
// Port-level checks for the ball projected gradient kernel, bound to its top level.
`default_nettype none
module l2bpg_checker #(
	parameter int WORD_BITS = 48
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic signed [WORD_BITS-1:0] res_first,
	input wire logic signed [WORD_BITS-1:0] res_second,
	input wire logic signed [WORD_BITS-1:0] res_third,
	input wire logic                        on_surface,
	input wire logic                        scaled
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_first) && $stable(res_second)
			&& $stable(res_third) && $stable(on_surface) && $stable(scaled))
		else $error("stalled result beat changed");

	// input backpressure comes only from a full, stalled output stage
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow output stage");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat present right after reset");

endmodule

bind l2_ball_projected_gradient l2bpg_checker #(.WORD_BITS(WORD_BITS)) u_l2bpg_checker (.*);
`default_nettype wire
